>>> rtl/core/dctt_pkg.sv
`default_nettype none

package dctt_pkg;

	localparam int TW = 48;
	localparam int IDW = 16;
	localparam int ARGW = 32;
	localparam int REMW = 5;
	localparam int SLOTS_DEF = 16;

	localparam logic [TW-1:0] T_MAX = {TW{1'b1}};
	localparam logic [REMW-1:0] REM_MAX = {REMW{1'b1}};

	localparam logic [1:0] KIND_SCHED = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_POLL = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] RES_SCHED = 3'd0;
	localparam logic [2:0] RES_FULL = 3'd1;
	localparam logic [2:0] RES_CANCEL = 3'd2;
	localparam logic [2:0] RES_FIRED = 3'd3;
	localparam logic [2:0] RES_NONE_DUE = 3'd4;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_APPEND,
		OP_CANCEL,
		OP_FIRE,
		OP_SHIFT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COMPACT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic valid;
		logic [IDW-1:0] tid;
		logic [TW-1:0] due;
		logic [ARGW-1:0] targ;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		logic [TW-1:0] now;
		logic [IDW-1:0] key;
		logic [TW-1:0] new_due;
		logic [ARGW-1:0] new_arg;
	} cell_cmd_t;

	typedef struct packed {
		logic valid;
		logic gap;
		logic due_seen;
		logic [TW-1:0] min_due;
	} link_t;

endpackage

`default_nettype wire

>>> rtl/core/dctt_cell.sv
`default_nettype none

module dctt_cell (
	input logic clk,
	input logic arst_n,
	input dctt_pkg::cell_cmd_t cmd,
	input dctt_pkg::link_t link_in,
	input dctt_pkg::entry_t next_in,
	output dctt_pkg::link_t link_out,
	output dctt_pkg::entry_t ent,
	output logic fire,
	output logic bubble
);

	logic valid_q;
	logic [dctt_pkg::IDW-1:0] tid_q;
	logic [dctt_pkg::TW-1:0] due_q;
	logic [dctt_pkg::ARGW-1:0] targ_q;
	logic [dctt_pkg::TW-1:0] min_q;
	logic [dctt_pkg::TW-1:0] cand;
	logic hit;
	logic gap;
	logic append;

	assign hit = valid_q && (cmd.now >= due_q);
	assign gap = link_in.gap || !valid_q;
	assign fire = hit && !link_in.due_seen;
	assign bubble = valid_q && link_in.gap;
	assign append = link_in.valid && !valid_q;
	assign cand = valid_q ? due_q : dctt_pkg::T_MAX;

	assign link_out.valid = valid_q;
	assign link_out.gap = gap;
	assign link_out.due_seen = link_in.due_seen || hit;
	assign link_out.min_due = min_q;

	assign ent.valid = valid_q;
	assign ent.tid = tid_q;
	assign ent.due = due_q;
	assign ent.targ = targ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				dctt_pkg::OP_APPEND: begin
					if (append) valid_q <= 1'b1;
				end
				dctt_pkg::OP_CANCEL: begin
					if (valid_q && tid_q == cmd.key) valid_q <= 1'b0;
				end
				dctt_pkg::OP_FIRE: begin
					if (fire) valid_q <= 1'b0;
				end
				dctt_pkg::OP_SHIFT: begin
					if (gap) valid_q <= next_in.valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		min_q <= (cand < link_in.min_due) ? cand : link_in.min_due;
		if (cmd.op == dctt_pkg::OP_APPEND && append) begin
			tid_q <= cmd.key;
			due_q <= cmd.new_due;
			targ_q <= cmd.new_arg;
		end else if (cmd.op == dctt_pkg::OP_SHIFT && gap) begin
			tid_q <= next_in.tid;
			due_q <= next_in.due;
			targ_q <= next_in.targ;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/deferred_call_timer_table_top.sv
// Channel | Dir | Handshake          | Payload
// s       | in  | s_tvalid, s_tready | s_tdata, s_tuser (kind)
// m       | out | m_tvalid, m_tready | m_tdata, m_tuser (result_kind)
//
// A schedule goes from accept through EVAL and DONE to its result; a kind-3 item is
// taken but gives no result. A cancel or a firing poll goes through EVAL, then COMPACT,
// which shifts entries through the cell chain until no gap is left, then DONE. A poll
// with nothing due waits in SCAN while the running minimum ripples down the chain, or
// skips SCAN on an empty table. Reset empties every slot at once. A result waiting on
// m_tready holds the next item in DONE; input is taken only between items.
`default_nettype none

module deferred_call_timer_table_top #(
	parameter int SLOTS = dctt_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [143:0] s_tdata, // now_us, delay_us, task_id, task_arg
	input logic [1:0] s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	output logic [103:0] m_tdata, // fired_task, fired_arg, wait_time, removed_count, zero pad
	output logic [2:0] m_tuser // result_kind
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int TW = dctt_pkg::TW;
	localparam int IDW = dctt_pkg::IDW;
	localparam int ARGW = dctt_pkg::ARGW;
	localparam int REMW = dctt_pkg::REMW;

	dctt_pkg::state_t state_q, state_d;
	logic [1:0] kind_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] delay_q;
	logic [IDW-1:0] tid_q;
	logic [ARGW-1:0] targ_q;
	logic [CW-1:0] old_cnt_q;
	logic [CW-1:0] scan_q;

	logic [2:0] res_kind_q, res_kind_d;
	logic [IDW-1:0] res_tid_q, res_tid_d;
	logic [ARGW-1:0] res_arg_q, res_arg_d;
	logic [TW-1:0] res_sleep_q, res_sleep_d;
	logic [REMW-1:0] res_rem_q, res_rem_d;
	logic res_ld, old_ld, out_ld;

	dctt_pkg::cell_op_t op;
	dctt_pkg::cell_cmd_t cmd;
	dctt_pkg::link_t lk [0:SLOTS];
	dctt_pkg::entry_t ent [0:SLOTS-1];
	dctt_pkg::entry_t nxt [0:SLOTS-1];
	logic [SLOTS-1:0] fire;
	logic [SLOTS-1:0] bubble;
	logic [SLOTS-1:0] vld;
	logic [SLOTS:0] vld_ext;

	logic [TW:0] sum;
	logic [TW-1:0] due_new;
	logic [CW-1:0] cnt;
	logic [CW-1:0] rem_full;
	logic [CW+REMW-1:0] rem_ext;
	logic [IDW-1:0] f_tid;
	logic [ARGW-1:0] f_arg;

	assign sum = {1'b0, now_q} + {1'b0, delay_q};
	assign due_new = sum[TW] ? dctt_pkg::T_MAX : sum[TW-1:0];

	assign cmd.op = op;
	assign cmd.now = now_q;
	assign cmd.key = tid_q;
	assign cmd.new_due = due_new;
	assign cmd.new_arg = targ_q;

	assign lk[0].valid = 1'b1;
	assign lk[0].gap = 1'b0;
	assign lk[0].due_seen = 1'b0;
	assign lk[0].min_due = dctt_pkg::T_MAX;

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			if (g == SLOTS - 1) begin : g_tail
				assign nxt[g] = '0;
			end else begin : g_mid
				assign nxt[g] = ent[g+1];
			end
			assign vld[g] = ent[g].valid;
			dctt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.link_in(lk[g]),
				.next_in(nxt[g]),
				.link_out(lk[g+1]),
				.ent(ent[g]),
				.fire(fire[g]),
				.bubble(bubble[g])
			);
		end
	endgenerate

	assign vld_ext = {1'b0, vld};

	// The valid entries form a prefix, so the fill count is where it ends.
	always_comb begin
		cnt = '0;
		f_tid = '0;
		f_arg = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (vld_ext[i] && !vld_ext[i+1]) cnt = CW'(i + 1);
			if (fire[i]) begin
				f_tid = f_tid | ent[i].tid;
				f_arg = f_arg | ent[i].targ;
			end
		end
	end

	assign rem_full = old_cnt_q - cnt;
	assign rem_ext = {{REMW{1'b0}}, rem_full};

	assign s_tready = (state_q == dctt_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		op = dctt_pkg::OP_IDLE;
		res_ld = 1'b0;
		old_ld = 1'b0;
		out_ld = 1'b0;
		res_kind_d = dctt_pkg::RES_SCHED;
		res_tid_d = '0;
		res_arg_d = '0;
		res_sleep_d = '0;
		res_rem_d = '0;
		unique case (state_q)
			dctt_pkg::ST_IDLE: begin
				if (s_tvalid && s_tuser != dctt_pkg::KIND_NONE) state_d = dctt_pkg::ST_EVAL;
			end
			dctt_pkg::ST_EVAL: begin
				case (kind_q)
					dctt_pkg::KIND_SCHED: begin
						res_ld = 1'b1;
						state_d = dctt_pkg::ST_DONE;
						if (vld[SLOTS-1]) begin
							res_kind_d = dctt_pkg::RES_FULL;
						end else begin
							op = dctt_pkg::OP_APPEND;
						end
					end
					dctt_pkg::KIND_CANCEL: begin
						op = dctt_pkg::OP_CANCEL;
						old_ld = 1'b1;
						state_d = dctt_pkg::ST_COMPACT;
					end
					default: begin
						if (lk[SLOTS].due_seen) begin
							op = dctt_pkg::OP_FIRE;
							res_ld = 1'b1;
							res_kind_d = dctt_pkg::RES_FIRED;
							res_tid_d = f_tid;
							res_arg_d = f_arg;
							state_d = dctt_pkg::ST_COMPACT;
						end else if (!vld[0]) begin
							res_ld = 1'b1;
							res_kind_d = dctt_pkg::RES_NONE_DUE;
							res_sleep_d = dctt_pkg::T_MAX;
							state_d = dctt_pkg::ST_DONE;
						end else begin
							state_d = dctt_pkg::ST_SCAN;
						end
					end
				endcase
			end
			dctt_pkg::ST_COMPACT: begin
				if (|bubble) begin
					op = dctt_pkg::OP_SHIFT;
				end else begin
					state_d = dctt_pkg::ST_DONE;
					if (kind_q == dctt_pkg::KIND_CANCEL) begin
						res_ld = 1'b1;
						res_kind_d = dctt_pkg::RES_CANCEL;
						res_rem_d = (rem_ext > (CW+REMW)'(dctt_pkg::REM_MAX)) ?
							dctt_pkg::REM_MAX : rem_ext[REMW-1:0];
					end
				end
			end
			dctt_pkg::ST_SCAN: begin
				if (scan_q == CW'(SLOTS - 1)) begin
					res_ld = 1'b1;
					res_kind_d = dctt_pkg::RES_NONE_DUE;
					res_sleep_d = lk[SLOTS].min_due - now_q;
					state_d = dctt_pkg::ST_DONE;
				end
			end
			dctt_pkg::ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					out_ld = 1'b1;
					state_d = dctt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dctt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dctt_pkg::ST_IDLE;
			scan_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dctt_pkg::ST_EVAL) begin
				scan_q <= '0;
			end else if (state_q == dctt_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (out_ld) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			now_q <= s_tdata[47:0];
			delay_q <= s_tdata[95:48];
			tid_q <= s_tdata[111:96];
			targ_q <= s_tdata[143:112];
		end
		if (old_ld) old_cnt_q <= cnt;
		if (res_ld) begin
			res_kind_q <= res_kind_d;
			res_tid_q <= res_tid_d;
			res_arg_q <= res_arg_d;
			res_sleep_q <= res_sleep_d;
			res_rem_q <= res_rem_d;
		end
		if (out_ld) begin
			m_tuser <= res_kind_q;
			m_tdata <= {3'b000, res_rem_q, res_sleep_q, res_arg_q, res_tid_q};
		end
	end

	a_prefix_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dctt_pkg::ST_IDLE |-> !(|bubble))
		else $error("Valid entries do not form a prefix while idle.");

	a_full_no_append: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dctt_pkg::ST_EVAL && kind_q == dctt_pkg::KIND_SCHED && vld[SLOTS-1])
		|=> $stable(vld))
		else $error("Schedule into a full table changed the slots.");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dctt_pkg::ST_DONE && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("Finished item did not present its result.");

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
	import dctt_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int RANDOM_BEATS = 925;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [IDW-1:0] id;
		logic [TW-1:0] due;
		logic [ARGW-1:0] arg;
	} pending_call_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [IDW-1:0] task_id;
		logic [ARGW-1:0] arg;
		logic [TW-1:0] sleep;
		logic [REMW-1:0] removed;
	} answer_t;

	class call_table_check;
		pending_call_t calls[$];
		answer_t answers_due[$];
		int fails;

		function new();
			fails = 0;
		endfunction

		function void note_input(logic [1:0] kind, logic [TW-1:0] now, logic [TW-1:0] delay,
				logic [IDW-1:0] id, logic [ARGW-1:0] arg);
			answer_t ans;
			pending_call_t c;
			logic [TW:0] sum;
			int cnt;
			bit fired;
			ans = '0;
			case (kind)
				KIND_SCHED: begin
					if (calls.size() >= SLOTS) begin
						ans.kind = RES_FULL;
					end else begin
						sum = {1'b0, now} + {1'b0, delay};
						c.id = id;
						c.due = sum[TW] ? T_MAX : sum[TW-1:0];
						c.arg = arg;
						calls.push_back(c);
						ans.kind = RES_SCHED;
					end
				end
				KIND_CANCEL: begin
					cnt = 0;
					for (int i = calls.size() - 1; i >= 0; i--) begin
						if (calls[i].id == id) begin
							calls.delete(i);
							cnt++;
						end
					end
					ans.kind = RES_CANCEL;
					ans.removed = (cnt > 31) ? REM_MAX : REMW'(cnt);
				end
				KIND_POLL: begin
					fired = 0;
					ans.sleep = T_MAX;
					for (int i = 0; i < calls.size(); i++) begin
						if (now >= calls[i].due) begin
							ans.kind = RES_FIRED;
							ans.task_id = calls[i].id;
							ans.arg = calls[i].arg;
							ans.sleep = '0;
							calls.delete(i);
							fired = 1;
							break;
						end
						if (calls[i].due - now < ans.sleep)
							ans.sleep = calls[i].due - now;
					end
					if (!fired)
						ans.kind = RES_NONE_DUE;
				end
				default: return;
			endcase
			answers_due.push_back(ans);
		endfunction

		function void check_result(answer_t got);
			answer_t want;
			if (answers_due.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("unexpected result beat: kind %0d task %h arg %h sleep %h removed %0d",
						got.kind, got.task_id, got.arg, got.sleep, got.removed);
				return;
			end
			want = answers_due.pop_front();
			if (got.kind !== want.kind || got.task_id !== want.task_id || got.arg !== want.arg ||
					got.sleep !== want.sleep || got.removed !== want.removed) begin
				fails++;
				if (fails <= REPORT_LIMIT) begin
					$write("result mismatch: expected kind %0d task %h arg %h sleep %h rem %0d;",
						want.kind, want.task_id, want.arg, want.sleep, want.removed);
					$display(" got kind %0d task %h arg %h sleep %h rem %0d",
						got.kind, got.task_id, got.arg, got.sleep, got.removed);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic [1:0] s_tuser = KIND_SCHED;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [2:0] m_tuser;

	int src_idle_pct = 13;
	int dst_idle_pct = 88;
	int cycle_cnt = 0;
	logic [TW-1:0] clock_now = '0;

	call_table_check sb = new();

	deferred_call_timer_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// Handshakes are sampled on the falling edge ahead of the rising edge that completes them.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result({m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[95:48],
					m_tdata[100:96]});
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[47:0], s_tdata[95:48], s_tdata[111:96],
					s_tdata[143:112]);
		end
	end

	task automatic send_beat(logic [1:0] kind, logic [TW-1:0] now, logic [TW-1:0] delay,
			logic [IDW-1:0] id, logic [ARGW-1:0] arg);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {arg, id, delay, now};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	function automatic logic [TW-1:0] rand_time();
		return TW'({$urandom(), $urandom()});
	endfunction

	task automatic random_beat(int sched_pct, output bit counted);
		int r;
		logic [1:0] kind;
		logic [TW-1:0] delay;
		logic [IDW-1:0] id;
		r = $urandom_range(99);
		if (r < sched_pct)
			kind = KIND_SCHED;
		else if (r < sched_pct + 12)
			kind = KIND_CANCEL;
		else if (r < 96)
			kind = KIND_POLL;
		else
			kind = KIND_NONE;

		r = $urandom_range(99);
		if (r < 3)
			clock_now = rand_time();
		else if (r < 5)
			clock_now = T_MAX - TW'($urandom_range(400));
		else
			clock_now = clock_now + TW'($urandom_range(60));

		r = $urandom_range(99);
		if (r < 70)
			delay = TW'($urandom_range(300));
		else if (r < 85)
			delay = rand_time();
		else if (r < 95)
			delay = T_MAX - TW'($urandom_range(300));
		else
			delay = '0;

		id = ($urandom_range(99) < 80) ? IDW'($urandom_range(7)) : IDW'($urandom());
		send_beat(kind, clock_now, delay, id, $urandom());
		counted = (kind != KIND_NONE);
	endtask

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int sent;
		int sched_pct;
		bit counted;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(KIND_POLL, '0, '0, '0, '0);
		send_beat(KIND_CANCEL, '0, '0, '0, '0);
		send_beat(KIND_NONE, T_MAX, T_MAX, '1, '1);
		send_beat(KIND_SCHED, T_MAX, T_MAX, '1, '1);
		send_beat(KIND_SCHED, '0, '0, '0, '0);
		for (int i = 0; i < SLOTS - 2; i++)
			send_beat(KIND_SCHED, TW'(1000), TW'(i * 10), IDW'(5), ARGW'(i));
		send_beat(KIND_SCHED, TW'(1000), TW'(1), IDW'(9), ARGW'(9));
		send_beat(KIND_POLL, '0, '0, '0, '0);
		send_beat(KIND_CANCEL, '0, '0, IDW'(5), '0);
		send_beat(KIND_POLL, T_MAX - 1, '0, '0, '0);
		send_beat(KIND_POLL, T_MAX, '0, '0, '0);

		sent = 0;
		sched_pct = 45;
		while (sent < RANDOM_BEATS) begin
			if (sent % 40 == 0)
				sched_pct = ($urandom_range(2) == 0) ? 20 : ($urandom_range(1) ? 45 : 70);
			if (sent == RANDOM_BEATS / 3) begin
				src_idle_pct = 88;
				dst_idle_pct = 13;
			end else if (sent == 2 * RANDOM_BEATS / 3) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			random_beat(sched_pct, counted);
			if (counted)
				sent++;
		end
		s_tvalid <= 1'b0;

		while (sb.answers_due.size() != 0)
			@(negedge clk);
		repeat (3 * SLOTS + 20) @(posedge clk);

		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

`default_nettype wire
